// File: design/stok_pkg.sv
`timescale 1ns / 1ps
// Shared types, token codes and character helpers for the source tokenizer.
// No dependencies; imported by every module of the block.
package stok_pkg;

    localparam int DefLineWidth   = 20;
    localparam int DefColumnWidth = 16;
    localparam int OutLineW       = 20;
    localparam int OutColW        = 16;
    localparam int QueueDepth     = 4;
    localparam int QueuePtrW      = $clog2(QueueDepth);
    localparam int NumKeywords    = 25;

    typedef struct packed {
        logic [7:0] src_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic                result_kind;
        logic [6:0]          token_kind;
        logic [63:0]         token_value;
        logic [OutLineW-1:0] start_line;
        logic [OutColW-1:0]  start_column;
        logic                unterminated;
        logic                last_of_run;
    } t_out_item;

    // Up to three results produced by one input transaction
    typedef struct packed {
        t_out_item [2:0] item;
        logic [1:0]      count;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [4:0] {
        M_IDLE, M_PEND, M_SHIFT, M_LCOMM, M_BCOMM, M_BSTAR, M_IDENT, M_ZERO,
        M_DEC, M_DOT, M_HEX, M_BIN, M_FRAC, M_EXPS, M_EXPD, M_STR, M_SESC,
        M_SHEX, M_COPEN, M_CESC, M_CHEX, M_CCLOSE, M_PRAGMA
    } t_lex_mode;

    localparam logic RK_TOKEN = 1'b0;
    localparam logic RK_TEXT  = 1'b1;

    localparam logic [6:0] TK_END     = 7'd0;
    localparam logic [6:0] TK_IDENT   = 7'd1;
    localparam logic [6:0] TK_INT     = 7'd2;
    localparam logic [6:0] TK_FLOAT   = 7'd3;
    localparam logic [6:0] TK_STR     = 7'd4;
    localparam logic [6:0] TK_CHAR    = 7'd5;
    localparam logic [6:0] TK_PRAGMA  = 7'd6;
    localparam logic [6:0] TK_ERROR   = 7'd7;
    localparam logic [6:0] TK_KW      = 7'd8;
    localparam logic [6:0] TK_LPAREN  = 7'd33;
    localparam logic [6:0] TK_RPAREN  = 7'd34;
    localparam logic [6:0] TK_LBRACE  = 7'd35;
    localparam logic [6:0] TK_RBRACE  = 7'd36;
    localparam logic [6:0] TK_LBRACK  = 7'd37;
    localparam logic [6:0] TK_RBRACK  = 7'd38;
    localparam logic [6:0] TK_COMMA   = 7'd39;
    localparam logic [6:0] TK_SEMI    = 7'd40;
    localparam logic [6:0] TK_COLON   = 7'd41;
    localparam logic [6:0] TK_DOT     = 7'd42;
    localparam logic [6:0] TK_QUEST   = 7'd43;
    localparam logic [6:0] TK_PLUS    = 7'd44;
    localparam logic [6:0] TK_INC     = 7'd45;
    localparam logic [6:0] TK_ADD_EQ  = 7'd46;
    localparam logic [6:0] TK_MINUS   = 7'd47;
    localparam logic [6:0] TK_ARROW   = 7'd48;
    localparam logic [6:0] TK_DECR    = 7'd49;
    localparam logic [6:0] TK_SUB_EQ  = 7'd50;
    localparam logic [6:0] TK_STAR    = 7'd51;
    localparam logic [6:0] TK_MUL_EQ  = 7'd52;
    localparam logic [6:0] TK_SLASH   = 7'd53;
    localparam logic [6:0] TK_DIV_EQ  = 7'd54;
    localparam logic [6:0] TK_PERCENT = 7'd55;
    localparam logic [6:0] TK_MOD_EQ  = 7'd56;
    localparam logic [6:0] TK_AMP     = 7'd57;
    localparam logic [6:0] TK_LAND    = 7'd58;
    localparam logic [6:0] TK_AND_EQ  = 7'd59;
    localparam logic [6:0] TK_PIPE    = 7'd60;
    localparam logic [6:0] TK_LOR     = 7'd61;
    localparam logic [6:0] TK_OR_EQ   = 7'd62;
    localparam logic [6:0] TK_CARET   = 7'd63;
    localparam logic [6:0] TK_XOR_EQ  = 7'd64;
    localparam logic [6:0] TK_TILDE   = 7'd65;
    localparam logic [6:0] TK_BANG    = 7'd66;
    localparam logic [6:0] TK_NE      = 7'd67;
    localparam logic [6:0] TK_LT      = 7'd68;
    localparam logic [6:0] TK_SHL     = 7'd69;
    localparam logic [6:0] TK_SHL_EQ  = 7'd70;
    localparam logic [6:0] TK_LE      = 7'd71;
    localparam logic [6:0] TK_GT      = 7'd72;
    localparam logic [6:0] TK_SHR     = 7'd73;
    localparam logic [6:0] TK_SHR_EQ  = 7'd74;
    localparam logic [6:0] TK_GE      = 7'd75;
    localparam logic [6:0] TK_ASSIGN  = 7'd76;
    localparam logic [6:0] TK_EQ      = 7'd77;

    localparam int KwLen [NumKeywords] = '{
        2, 6, 2, 4, 5, 2, 3, 5, 8, 6, 8, 4, 9, 6, 6, 5, 3, 6, 4, 4, 5, 3, 4, 6, 5};
    // Right-justified text, first character in the highest used byte
    localparam logic [79:0] KwStr [NumKeywords] = '{
        "fn", "return", "if", "else", "while", "do", "for", "break", "continue",
        "struct", "protocol", "impl", "component", "system", "extern", "const",
        "new", "delete", "null", "true", "false", "ent", "void", "sizeof", "world"};

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
        logic [7:0] r;
        r = 8'd0;
        if (int'(p) < KwLen[k]) begin
            r = KwStr[k][(KwLen[k] - 1 - int'(p)) * 8 +: 8];
        end
        return r;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] r;
        if (is_digit(c)) begin
            r = c - "0";
        end else if (c >= "a" && c <= "f") begin
            r = c - "a" + 8'd10;
        end else begin
            r = c - "A" + 8'd10;
        end
        return r[3:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
    endfunction

    function automatic logic [6:0] op_now(input logic [7:0] c);
        logic [6:0] r;
        case (c)
            "(":     r = TK_LPAREN;
            ")":     r = TK_RPAREN;
            "{":     r = TK_LBRACE;
            "}":     r = TK_RBRACE;
            "[":     r = TK_LBRACK;
            "]":     r = TK_RBRACK;
            ",":     r = TK_COMMA;
            ";":     r = TK_SEMI;
            ":":     r = TK_COLON;
            ".":     r = TK_DOT;
            "?":     r = TK_QUEST;
            "~":     r = TK_TILDE;
            default: r = TK_END;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] op_alone(input logic [7:0] f);
        logic [6:0] r;
        case (f)
            "+":     r = TK_PLUS;
            "-":     r = TK_MINUS;
            "*":     r = TK_STAR;
            "/":     r = TK_SLASH;
            "%":     r = TK_PERCENT;
            "&":     r = TK_AMP;
            "|":     r = TK_PIPE;
            "^":     r = TK_CARET;
            "!":     r = TK_BANG;
            "<":     r = TK_LT;
            ">":     r = TK_GT;
            "=":     r = TK_ASSIGN;
            default: r = TK_END;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] op_pair(input logic [7:0] f, input logic [7:0] b);
        logic [6:0] r;
        case (f)
            "+":     r = b == "+" ? TK_INC : b == "=" ? TK_ADD_EQ : TK_END;
            "-":     r = b == ">" ? TK_ARROW : b == "-" ? TK_DECR
                       : b == "=" ? TK_SUB_EQ : TK_END;
            "*":     r = b == "=" ? TK_MUL_EQ : TK_END;
            "/":     r = b == "=" ? TK_DIV_EQ : TK_END;
            "%":     r = b == "=" ? TK_MOD_EQ : TK_END;
            "&":     r = b == "&" ? TK_LAND : b == "=" ? TK_AND_EQ : TK_END;
            "|":     r = b == "|" ? TK_LOR : b == "=" ? TK_OR_EQ : TK_END;
            "^":     r = b == "=" ? TK_XOR_EQ : TK_END;
            "!":     r = b == "=" ? TK_NE : TK_END;
            "<":     r = b == "=" ? TK_LE : TK_END;
            ">":     r = b == "=" ? TK_GE : TK_END;
            "=":     r = b == "=" ? TK_EQ : TK_END;
            default: r = TK_END;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            "n":     r = 8'h0A;
            "t":     r = 8'h09;
            "r":     r = 8'h0D;
            "0":     r = 8'h00;
            default: r = e;
        endcase
        return r;
    endfunction

endpackage

// File: design/stok_front.sv
`timescale 1ns / 1ps
// Front end: takes source bytes, runs the lexer state and packs the results
// of each transaction into one bundle for the queue. Uses stok_pkg.
module stok_front #(
    parameter int LINE_WIDTH   = stok_pkg::DefLineWidth,
    parameter int COLUMN_WIDTH = stok_pkg::DefColumnWidth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  stok_pkg::t_in_item  i_in,
    output logic                o_in_stall,
    input  stok_pkg::t_q_status i_q_status,
    output logic                o_push,
    output stok_pkg::t_bundle   o_bundle
);
    import stok_pkg::*;

    typedef logic [LINE_WIDTH-1:0]   t_line;
    typedef logic [COLUMN_WIDTH-1:0] t_col;

    typedef struct packed {
        t_lex_mode   mode;
        t_line       tl;
        t_col        tc;
        t_col        hc;
        logic [63:0] acc;
        logic        sat;
        logic [24:0] kw;
        logic [3:0]  wl;
        logic [7:0]  esc;
        logic [1:0]  escd;
        logic [7:0]  pop;
    } t_lex;

    typedef struct packed {
        t_lex            st;
        t_out_item [2:0] it;
        logic [1:0]      n;
        logic            again;
    } t_work;

    localparam t_lex LexReset = '{
        mode: M_IDLE, tl: t_line'(1), tc: t_col'(1), hc: t_col'(1), acc: 64'd0,
        sat: 1'b0, kw: '1, wl: 4'd0, esc: 8'd0, escd: 2'd0, pop: 8'd0};

    function automatic t_work put(input t_work w, input logic rk, input logic [6:0] tk,
                                  input logic [63:0] v, input t_line ln, input t_col cl,
                                  input logic u);
        t_work     r;
        t_out_item it;
        r = w;
        it.result_kind  = rk;
        it.token_kind   = tk;
        it.token_value  = v;
        it.start_line   = OutLineW'(ln);
        it.start_column = OutColW'(cl);
        it.unterminated = u;
        it.last_of_run  = 1'b0;
        if (r.n != 2'd3) begin
            r.it[r.n] = it;
            r.n = r.n + 2'd1;
        end
        return r;
    endfunction

    function automatic t_work text(input t_work w, input logic [7:0] b);
        return put(w, RK_TEXT, TK_END, {56'd0, b}, w.st.tl, w.st.tc, 1'b0);
    endfunction

    function automatic t_work tok(input t_work w, input logic [6:0] k,
                                  input logic [63:0] v, input logic u);
        return put(w, RK_TOKEN, k, v, w.st.tl, w.st.tc, u);
    endfunction

    function automatic t_lex ident_char(input t_lex s, input logic [7:0] c);
        t_lex r;
        r = s;
        for (int k = 0; k < NumKeywords; k++) begin
            if (int'(s.wl) >= KwLen[k] || kw_char(k, s.wl) != c) begin
                r.kw[k] = 1'b0;
            end
        end
        r.wl = (s.wl != 4'd15) ? s.wl + 4'd1 : s.wl;
        return r;
    endfunction

    function automatic logic [6:0] ident_kind(input t_lex s);
        logic [6:0] kind;
        kind = TK_IDENT;
        for (int k = NumKeywords - 1; k >= 0; k--) begin
            if (s.kw[k] && KwLen[k] == int'(s.wl)) begin
                kind = TK_KW + 7'(k);
            end
        end
        return kind;
    endfunction

    // One pass of the lexer over the byte; sets again when the byte must be
    // looked at once more in the mode just entered
    function automatic t_work lex_run(input t_work w, input logic [7:0] b,
                                      input t_line cl, input t_col cc);
        t_work       r;
        logic [7:0]  f;
        logic [6:0]  k;
        logic [67:0] m;
        logic [7:0]  e;
        r = w;
        f = w.st.pop;
        k = TK_END;
        m = 68'd0;
        e = 8'd0;
        if (w.again) begin
            r.again = 1'b0;
            case (w.st.mode)
                M_IDLE: begin
                    r.st.tl = cl;
                    r.st.tc = cc;
                    k = op_now(b);
                    if (is_blank(b)) begin
                        r.st.mode = M_IDLE;
                    end else if (is_alpha(b) || b == "_") begin
                        r.st.mode = M_IDENT;
                        r.st.kw = '1;
                        r.st.wl = 4'd0;
                        r.st = ident_char(r.st, b);
                        r = text(r, b);
                    end else if (is_digit(b)) begin
                        r.st.acc = {60'd0, hex_val(b)};
                        r.st.sat = 1'b0;
                        r.st.mode = (b == "0") ? M_ZERO : M_DEC;
                        r = text(r, b);
                    end else if (b == "\"") begin
                        r.st.mode = M_STR;
                    end else if (b == "'") begin
                        r.st.acc = 64'd0;
                        r.st.mode = M_COPEN;
                    end else if (b == "#") begin
                        r.st.mode = M_PRAGMA;
                    end else if (k != TK_END) begin
                        r = tok(r, k, 64'd0, 1'b0);
                    end else if (op_alone(b) != TK_END) begin
                        r.st.pop = b;
                        r.st.mode = M_PEND;
                    end else begin
                        r = tok(r, TK_ERROR, {56'd0, b}, 1'b1);
                    end
                end
                M_PEND: begin
                    k = op_pair(f, b);
                    if (f == "/" && b == "/") begin
                        r.st.mode = M_LCOMM;
                    end else if (f == "/" && b == "*") begin
                        r.st.mode = M_BCOMM;
                    end else if ((f == "<" || f == ">") && b == f) begin
                        r.st.mode = M_SHIFT;
                    end else begin
                        r.st.mode = M_IDLE;
                        if (k != TK_END) begin
                            r = tok(r, k, 64'd0, 1'b0);
                        end else begin
                            r = tok(r, op_alone(f), 64'd0, 1'b0);
                            r.again = 1'b1;
                        end
                    end
                end
                M_SHIFT: begin
                    r.st.mode = M_IDLE;
                    if (b == "=") begin
                        r = tok(r, (f == "<") ? TK_SHL_EQ : TK_SHR_EQ, 64'd0, 1'b0);
                    end else begin
                        r = tok(r, (f == "<") ? TK_SHL : TK_SHR, 64'd0, 1'b0);
                        r.again = 1'b1;
                    end
                end
                M_LCOMM: begin
                    if (b == 8'h0A) r.st.mode = M_IDLE;
                end
                M_BCOMM: begin
                    if (b == "*") r.st.mode = M_BSTAR;
                end
                M_BSTAR: begin
                    if (b == "/") begin
                        r.st.mode = M_IDLE;
                    end else if (b != "*") begin
                        r.st.mode = M_BCOMM;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == "_") begin
                        r.st = ident_char(r.st, b);
                        r = text(r, b);
                    end else begin
                        r = tok(r, ident_kind(r.st), 64'd0, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_ZERO, M_DEC: begin
                    if (w.st.mode == M_ZERO && (b == "x" || b == "X")) begin
                        r.st.mode = M_HEX;
                        r = text(r, b);
                    end else if (w.st.mode == M_ZERO && (b == "b" || b == "B")) begin
                        r.st.mode = M_BIN;
                        r = text(r, b);
                    end else if (is_digit(b)) begin
                        r.st.mode = M_DEC;
                        // acc * 10 + d, saturating when it no longer fits 64 bits
                        m = ({4'd0, w.st.acc} << 3) + ({4'd0, w.st.acc} << 1)
                            + {64'd0, hex_val(b)};
                        if (w.st.sat || m[67:64] != 4'd0) begin
                            r.st.acc = '1;
                            r.st.sat = 1'b1;
                        end else begin
                            r.st.acc = m[63:0];
                        end
                        r = text(r, b);
                    end else if (b == ".") begin
                        r.st.hc = cc;
                        r.st.mode = M_DOT;
                    end else if (b == "e" || b == "E") begin
                        r.st.mode = M_EXPS;
                        r = text(r, b);
                    end else begin
                        r = tok(r, TK_INT, w.st.acc, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(b)) begin
                        r = text(r, ".");
                        r = text(r, b);
                        r.st.mode = M_FRAC;
                    end else begin
                        r = tok(r, TK_INT, w.st.acc, 1'b0);
                        r = put(r, RK_TOKEN, TK_DOT, 64'd0, cl, w.st.hc, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex(b)) begin
                        if (w.st.sat || w.st.acc[63:60] != 4'd0) begin
                            r.st.acc = '1;
                            r.st.sat = 1'b1;
                        end else begin
                            r.st.acc = {w.st.acc[59:0], hex_val(b)};
                        end
                        r = text(r, b);
                    end else begin
                        r = tok(r, TK_INT, w.st.acc, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_BIN: begin
                    if (b == "0" || b == "1") begin
                        if (w.st.sat || w.st.acc[63]) begin
                            r.st.acc = '1;
                            r.st.sat = 1'b1;
                        end else begin
                            r.st.acc = {w.st.acc[62:0], b[0]};
                        end
                        r = text(r, b);
                    end else begin
                        r = tok(r, TK_INT, w.st.acc, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_FRAC, M_EXPS, M_EXPD: begin
                    if (is_digit(b)) begin
                        if (w.st.mode == M_EXPS) r.st.mode = M_EXPD;
                        r = text(r, b);
                    end else if (w.st.mode == M_FRAC && (b == "e" || b == "E")) begin
                        r.st.mode = M_EXPS;
                        r = text(r, b);
                    end else if (w.st.mode == M_EXPS && (b == "+" || b == "-")) begin
                        r.st.mode = M_EXPD;
                        r = text(r, b);
                    end else begin
                        r = tok(r, TK_FLOAT, 64'd0, 1'b0);
                        r.st.mode = M_IDLE;
                        r.again = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == "\"") begin
                        r = tok(r, TK_STR, 64'd0, 1'b0);
                        r.st.mode = M_IDLE;
                    end else if (b == "\\") begin
                        r.st.mode = M_SESC;
                    end else begin
                        r = text(r, b);
                    end
                end
                M_SESC: begin
                    if (b == "x") begin
                        r.st.esc = 8'd0;
                        r.st.escd = 2'd0;
                        r.st.mode = M_SHEX;
                    end else begin
                        r = text(r, esc_code(b));
                        r.st.mode = M_STR;
                    end
                end
                M_SHEX: begin
                    if (is_hex(b)) begin
                        e = {w.st.esc[3:0], hex_val(b)};
                        r.st.esc = e;
                        r.st.escd = w.st.escd + 2'd1;
                        if (r.st.escd[1]) begin
                            r = text(r, e);
                            r.st.mode = M_STR;
                        end
                    end else begin
                        r = text(r, w.st.esc);
                        r.st.mode = M_STR;
                        r.again = 1'b1;
                    end
                end
                M_COPEN: begin
                    if (b == "\\") begin
                        r.st.mode = M_CESC;
                    end else begin
                        r.st.acc = {56'd0, b};
                        r.st.mode = M_CCLOSE;
                    end
                end
                M_CESC: begin
                    if (b == "x") begin
                        r.st.esc = 8'd0;
                        r.st.escd = 2'd0;
                        r.st.acc = 64'd0;
                        r.st.mode = M_CHEX;
                    end else begin
                        r.st.acc = {56'd0, esc_code(b)};
                        r.st.mode = M_CCLOSE;
                    end
                end
                M_CHEX: begin
                    if (is_hex(b)) begin
                        e = {w.st.esc[3:0], hex_val(b)};
                        r.st.esc = e;
                        r.st.escd = w.st.escd + 2'd1;
                        r.st.acc = {56'd0, e};
                        if (r.st.escd[1]) r.st.mode = M_CCLOSE;
                    end else begin
                        r.st.acc = {56'd0, w.st.esc};
                        r.st.mode = M_CCLOSE;
                        r.again = 1'b1;
                    end
                end
                M_CCLOSE: begin
                    r.st.mode = M_IDLE;
                    if (b == "'") begin
                        r = tok(r, TK_CHAR, w.st.acc, 1'b0);
                    end else begin
                        r = tok(r, TK_CHAR, w.st.acc, 1'b1);
                        r.again = 1'b1;
                    end
                end
                M_PRAGMA: begin
                    if (b == 8'h0A) begin
                        r = tok(r, TK_PRAGMA, 64'd0, 1'b0);
                        r.st.mode = M_IDLE;
                    end else begin
                        r = text(r, b);
                    end
                end
                default: begin
                    r.st.mode = M_IDLE;
                    r.again = 1'b1;
                end
            endcase
        end
        return r;
    endfunction

    // Close whatever token is open at end of input
    function automatic t_work flush(input t_work w, input t_line cl);
        t_work      r;
        logic [7:0] f;
        r = w;
        f = w.st.pop;
        case (w.st.mode)
            M_PEND:   r = tok(r, op_alone(f), 64'd0, 1'b0);
            M_SHIFT:  r = tok(r, (f == "<") ? TK_SHL : TK_SHR, 64'd0, 1'b0);
            M_IDENT:  r = tok(r, ident_kind(w.st), 64'd0, 1'b0);
            M_ZERO, M_DEC, M_HEX, M_BIN: r = tok(r, TK_INT, w.st.acc, 1'b0);
            M_DOT: begin
                r = tok(r, TK_INT, w.st.acc, 1'b0);
                r = put(r, RK_TOKEN, TK_DOT, 64'd0, cl, w.st.hc, 1'b0);
            end
            M_FRAC, M_EXPS, M_EXPD: r = tok(r, TK_FLOAT, 64'd0, 1'b0);
            M_STR, M_SESC: r = tok(r, TK_STR, 64'd0, 1'b1);
            M_SHEX: begin
                r = text(r, w.st.esc);
                r = tok(r, TK_STR, 64'd0, 1'b1);
            end
            M_COPEN, M_CESC: r = tok(r, TK_CHAR, 64'd0, 1'b1);
            M_CHEX:   r = tok(r, TK_CHAR, {56'd0, w.st.esc}, 1'b1);
            M_CCLOSE: r = tok(r, TK_CHAR, w.st.acc, 1'b1);
            M_PRAGMA: r = tok(r, TK_PRAGMA, 64'd0, 1'b0);
            default:  r = w;
        endcase
        return r;
    endfunction

    t_lex  r_st, n_st;
    t_line r_line, n_line;
    t_col  r_col, n_col;
    t_work w0, w1, w2, w3, wf;
    logic  accept;

    assign o_in_stall = i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    always_comb begin
        w0.st    = r_st;
        w0.it    = '0;
        w0.n     = 2'd0;
        w0.again = 1'b1;
        // a byte is seen at most three times: char hex escape, close, idle
        w1 = lex_run(w0, i_in.src_byte, r_line, r_col);
        w2 = lex_run(w1, i_in.src_byte, r_line, r_col);
        w3 = lex_run(w2, i_in.src_byte, r_line, r_col);
        if (i_in.end_of_input) begin
            wf = flush(w0, r_line);
            wf = put(wf, RK_TOKEN, TK_END, 64'd0, r_line, r_col, 1'b0);
            wf.st = LexReset;
        end else begin
            wf = w3;
        end
        if (wf.n != 2'd0) begin
            wf.it[wf.n - 2'd1].last_of_run = 1'b1;
        end
    end

    always_comb begin
        n_st   = r_st;
        n_line = r_line;
        n_col  = r_col;
        if (accept) begin
            n_st = wf.st;
            if (i_in.end_of_input) begin
                n_line = t_line'(1);
                n_col  = t_col'(1);
            end else if (i_in.src_byte == 8'h0A) begin
                n_line = (r_line != '1) ? r_line + t_line'(1) : r_line;
                n_col  = t_col'(1);
            end else begin
                n_col = (r_col != '1) ? r_col + t_col'(1) : r_col;
            end
        end
    end

    assign o_push         = accept && (wf.n != 2'd0);
    assign o_bundle.item  = wf.it;
    assign o_bundle.count = wf.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= LexReset;
            r_line <= t_line'(1);
            r_col  <= t_col'(1);
        end else begin
            r_st   <= n_st;
            r_line <= n_line;
            r_col  <= n_col;
        end
    end

endmodule

// File: design/stok_queue.sv
`timescale 1ns / 1ps
// Short queue of result bundles between the front and back ends.
// Uses stok_pkg.
module stok_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  stok_pkg::t_bundle   i_bundle,
    input  logic                i_pop,
    output stok_pkg::t_bundle   o_head,
    output stok_pkg::t_q_status o_status
);
    import stok_pkg::*;

    t_bundle              r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [QueuePtrW:0]   r_cnt, n_cnt;
    logic                 do_push, do_pop;

    assign o_status.full  = (r_cnt == (QueuePtrW+1)'(QueueDepth));
    assign o_status.empty = (r_cnt == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr  = do_push ? r_wr + 1'b1 : r_wr;
        n_rd  = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (QueuePtrW+1)'(do_push) - (QueuePtrW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/stok_back.sv
`timescale 1ns / 1ps
// Back end: walks the head bundle one result per cycle, while the output is not
// stalled, into the output register. Uses stok_pkg.
module stok_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stok_pkg::t_bundle   i_head,
    input  stok_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    output stok_pkg::t_out_item o_out,
    input  logic                i_out_stall
);
    import stok_pkg::*;

    logic       r_valid, n_valid;
    t_out_item  r_out;
    logic [1:0] r_idx, n_idx;
    logic       load, at_last;

    assign load    = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign at_last = (r_idx == i_head.count - 2'd1);
    assign o_pop   = load && at_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = at_last ? 2'd0 : r_idx + 2'd1;
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_head.item[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

// File: design/source_tokenizer_unit.sv
`timescale 1ns / 1ps
// Source tokenizer. One byte is taken per cycle while the bundle queue has room;
// each byte yields zero to three results, which leave one per cycle unless the output stalls.
// Path: the results of a byte enter the bundle queue as one entry and then pass
// to the output register; any further results follow one per cycle unless stalled.
// Throughput: one byte per cycle, bounded by the output at one result per cycle;
// the four-entry bundle queue absorbs bursts of up to three results per byte.
// Reset (synchronous, active low) empties the queue and sets line and column to 1.
module source_tokenizer_unit #(
    parameter int LINE_WIDTH   = stok_pkg::DefLineWidth,
    parameter int COLUMN_WIDTH = stok_pkg::DefColumnWidth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  stok_pkg::t_in_item  i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output stok_pkg::t_out_item o_out,
    input  logic                i_out_stall
);
    import stok_pkg::*;

    t_bundle   push_bundle, head;
    t_q_status q_status;
    logic      push, pop;

    stok_front #(
        .LINE_WIDTH  (LINE_WIDTH),
        .COLUMN_WIDTH(COLUMN_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in      (i_in),
        .o_in_stall(o_in_stall),
        .i_q_status(q_status),
        .o_push    (push),
        .o_bundle  (push_bundle)
    );

    stok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_bundle(push_bundle),
        .i_pop   (pop),
        .o_head  (head),
        .o_status(q_status)
    );

    stok_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_out      (o_out),
        .i_out_stall(i_out_stall)
    );

endmodule

// File: design/stok_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the source tokenizer, bound to the top level.
// Uses stok_pkg.
module stok_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input stok_pkg::t_in_item  i_in,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input stok_pkg::t_out_item o_out,
    input logic                i_out_stall
);
    import stok_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled output transaction changed");

    a_text_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.result_kind == RK_TEXT
        |-> o_out.token_kind == TK_END && !o_out.unterminated)
        else $error("text item carries token fields");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.result_kind == RK_TOKEN && o_out.token_kind == TK_END
        |-> o_out.last_of_run && o_out.token_value == 64'd0)
        else $error("end token not last of its run");

endmodule

bind source_tokenizer_unit stok_checker u_stok_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for source_tokenizer_unit: drives source bytes, predicts every
// text and token result in-bench and checks them in order. Depends on stok_pkg.
module tb;
    import stok_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    t_in_item  i_in;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out;
    logic      i_out_stall = 1'b0;

    source_tokenizer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    localparam logic [19:0] LineTop = 20'hFFFFF;
    localparam logic [15:0] ColTop  = 16'hFFFF;
    localparam logic [7:0]  Lf      = 8'h0A;

    string kw_names [25] = '{
        "fn", "return", "if", "else", "while", "do", "for", "break", "continue",
        "struct", "protocol", "impl", "component", "system", "extern", "const",
        "new", "delete", "null", "true", "false", "ent", "void", "sizeof", "world"};
    string op_names [45] = '{
        "(", ")", "{", "}", "[", "]", ",", ";", ":", ".", "?", "+", "++", "+=", "-",
        "->", "--", "-=", "*", "*=", "/", "/=", "%", "%=", "&", "&&", "&=", "|", "||",
        "|=", "^", "^=", "~", "!", "!=", "<", "<<", "<<=", "<=", ">", ">>", ">>=", ">=",
        "=", "=="};

    // lexer shadow state
    t_lex_mode   lx_mode;
    logic [19:0] line_c, cur_line, tok_line;
    logic [15:0] col_c, cur_col, tok_col, held_col;
    logic [63:0] num_acc;
    logic        num_sat;
    logic [24:0] kw_cand;
    logic [3:0]  word_len;
    logic [7:0]  esc_acc;
    logic [1:0]  esc_digs;
    logic [7:0]  pend_op;

    t_out_item step_q [$];
    t_out_item tokens_due [$];
    logic [7:0] frag_q [$];
    int  errors = 0;
    bit  idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(12 * 1_500_000);
        $display("status: fail");
        $finish;
    end

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_hexc(logic [7:0] c);
        return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic logic [3:0] hexv(logic [7:0] c);
        logic [7:0] r;
        if (is_num(c)) r = c - "0";
        else if (c >= "a" && c <= "f") r = c - "a" + 8'd10;
        else r = c - "A" + 8'd10;
        return r[3:0];
    endfunction
    function automatic logic [7:0] unescape(logic [7:0] e);
        case (e)
            "n": return 8'h0A;
            "t": return 8'h09;
            "r": return 8'h0D;
            "0": return 8'h00;
            default: return e;
        endcase
    endfunction

    function automatic logic [6:0] single_op(logic [7:0] c);
        case (c)
            "(": return TK_LPAREN;  ")": return TK_RPAREN;
            "{": return TK_LBRACE;  "}": return TK_RBRACE;
            "[": return TK_LBRACK;  "]": return TK_RBRACK;
            ",": return TK_COMMA;   ";": return TK_SEMI;
            ":": return TK_COLON;   ".": return TK_DOT;
            "?": return TK_QUEST;   "~": return TK_TILDE;
            default: return TK_END;
        endcase
    endfunction
    function automatic logic [6:0] lead_op(logic [7:0] f);
        case (f)
            "+": return TK_PLUS;    "-": return TK_MINUS;
            "*": return TK_STAR;    "/": return TK_SLASH;
            "%": return TK_PERCENT; "&": return TK_AMP;
            "|": return TK_PIPE;    "^": return TK_CARET;
            "!": return TK_BANG;    "<": return TK_LT;
            ">": return TK_GT;      "=": return TK_ASSIGN;
            default: return TK_END;
        endcase
    endfunction
    function automatic logic [6:0] two_op(logic [7:0] f, logic [7:0] b);
        case (f)
            "+": return b == "+" ? TK_INC : b == "=" ? TK_ADD_EQ : TK_END;
            "-": return b == ">" ? TK_ARROW : b == "-" ? TK_DECR
                      : b == "=" ? TK_SUB_EQ : TK_END;
            "*": return b == "=" ? TK_MUL_EQ : TK_END;
            "/": return b == "=" ? TK_DIV_EQ : TK_END;
            "%": return b == "=" ? TK_MOD_EQ : TK_END;
            "&": return b == "&" ? TK_LAND : b == "=" ? TK_AND_EQ : TK_END;
            "|": return b == "|" ? TK_LOR : b == "=" ? TK_OR_EQ : TK_END;
            "^": return b == "=" ? TK_XOR_EQ : TK_END;
            "!": return b == "=" ? TK_NE : TK_END;
            "<": return b == "=" ? TK_LE : TK_END;
            ">": return b == "=" ? TK_GE : TK_END;
            "=": return b == "=" ? TK_EQ : TK_END;
            default: return TK_END;
        endcase
    endfunction

    function automatic void clear_lexer();
        lx_mode = M_IDLE;
        line_c = 20'd1; col_c = 16'd1; tok_line = 20'd1; tok_col = 16'd1;
        held_col = 16'd1; num_acc = '0; num_sat = 1'b0; kw_cand = '1;
        word_len = '0; esc_acc = '0; esc_digs = '0; pend_op = '0;
    endfunction

    function automatic void push_res(logic rk, logic [6:0] tk, logic [63:0] v,
                                     logic [19:0] ln, logic [15:0] col, logic u);
        t_out_item r;
        if (step_q.size() >= 3) return;
        r.result_kind = rk; r.token_kind = tk; r.token_value = v;
        r.start_line = ln; r.start_column = col; r.unterminated = u;
        r.last_of_run = 1'b0;
        step_q = {step_q, r};
    endfunction
    function automatic void text_res(logic [7:0] b);
        push_res(RK_TEXT, TK_END, {56'd0, b}, tok_line, tok_col, 1'b0);
    endfunction
    function automatic void tok_res(logic [6:0] k, logic [63:0] v, logic u);
        push_res(RK_TOKEN, k, v, tok_line, tok_col, u);
    endfunction

    function automatic void word_char(logic [7:0] c);
        for (int k = 0; k < 25; k++)
            if (int'(word_len) >= kw_names[k].len() || kw_names[k][word_len] != c)
                kw_cand[k] = 1'b0;
        if (word_len != 4'd15) word_len = word_len + 4'd1;
    endfunction
    function automatic void close_word();
        logic [6:0] kind;
        bit found;
        kind = TK_IDENT; found = 0;
        for (int k = 0; k < 25; k++)
            if (!found && kw_cand[k] && kw_names[k].len() == int'(word_len)) begin
                kind = TK_KW + 7'(k); found = 1;
            end
        tok_res(kind, '0, 1'b0);
    endfunction

    function automatic void add_dec(logic [63:0] d);
        if (num_sat || num_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
            num_acc = '1; num_sat = 1'b1;
        end else num_acc = num_acc * 64'd10 + d;
    endfunction

    function automatic void lex_byte(logic [7:0] b);
        logic [7:0] f;
        logic [6:0] k;
        f = pend_op;
        case (lx_mode)
            M_IDLE: begin
                tok_line = cur_line; tok_col = cur_col;
                if (b == " " || b == 8'h09 || b == 8'h0D || b == Lf) return;
                if (is_letter(b) || b == "_") begin
                    lx_mode = M_IDENT; kw_cand = '1; word_len = '0;
                    word_char(b); text_res(b);
                end else if (is_num(b)) begin
                    num_acc = 64'(b - "0"); num_sat = 1'b0;
                    lx_mode = (b == "0") ? M_ZERO : M_DEC; text_res(b);
                end else if (b == "\"") lx_mode = M_STR;
                else if (b == "'") begin num_acc = '0; lx_mode = M_COPEN; end
                else if (b == "#") lx_mode = M_PRAGMA;
                else if (single_op(b) != TK_END) tok_res(single_op(b), '0, 1'b0);
                else if (lead_op(b) != TK_END) begin pend_op = b; lx_mode = M_PEND; end
                else tok_res(TK_ERROR, {56'd0, b}, 1'b1);
            end
            M_PEND: begin
                if (f == "/" && b == "/") begin lx_mode = M_LCOMM; return; end
                if (f == "/" && b == "*") begin lx_mode = M_BCOMM; return; end
                if ((f == "<" || f == ">") && b == f) begin lx_mode = M_SHIFT; return; end
                k = two_op(f, b);
                lx_mode = M_IDLE;
                if (k != TK_END) tok_res(k, '0, 1'b0);
                else begin tok_res(lead_op(f), '0, 1'b0); lex_byte(b); end
            end
            M_SHIFT: begin
                lx_mode = M_IDLE;
                if (b == "=") tok_res(f == "<" ? TK_SHL_EQ : TK_SHR_EQ, '0, 1'b0);
                else begin tok_res(f == "<" ? TK_SHL : TK_SHR, '0, 1'b0); lex_byte(b); end
            end
            M_LCOMM: if (b == Lf) lx_mode = M_IDLE;
            M_BCOMM: if (b == "*") lx_mode = M_BSTAR;
            M_BSTAR: begin
                if (b == "/") lx_mode = M_IDLE;
                else if (b != "*") lx_mode = M_BCOMM;
            end
            M_IDENT: begin
                if (is_letter(b) || is_num(b) || b == "_") begin word_char(b); text_res(b); end
                else begin close_word(); lx_mode = M_IDLE; lex_byte(b); end
            end
            M_ZERO, M_DEC: begin
                if (lx_mode == M_ZERO && (b == "x" || b == "X")) begin
                    lx_mode = M_HEX; text_res(b);
                end else if (lx_mode == M_ZERO && (b == "b" || b == "B")) begin
                    lx_mode = M_BIN; text_res(b);
                end else if (is_num(b)) begin
                    lx_mode = M_DEC; add_dec(64'(b - "0")); text_res(b);
                end else if (b == ".") begin
                    held_col = cur_col; lx_mode = M_DOT;
                end else if (b == "e" || b == "E") begin
                    lx_mode = M_EXPS; text_res(b);
                end else begin
                    tok_res(TK_INT, num_acc, 1'b0); lx_mode = M_IDLE; lex_byte(b);
                end
            end
            M_DOT: begin
                if (is_num(b)) begin text_res("."); text_res(b); lx_mode = M_FRAC; end
                else begin
                    tok_res(TK_INT, num_acc, 1'b0);
                    push_res(RK_TOKEN, TK_DOT, '0, cur_line, held_col, 1'b0);
                    lx_mode = M_IDLE; lex_byte(b);
                end
            end
            M_HEX: begin
                if (is_hexc(b)) begin
                    if (num_sat || num_acc[63:60] != 4'd0) begin
                        num_acc = '1; num_sat = 1'b1;
                    end else num_acc = {num_acc[59:0], hexv(b)};
                    text_res(b);
                end else begin
                    tok_res(TK_INT, num_acc, 1'b0); lx_mode = M_IDLE; lex_byte(b);
                end
            end
            M_BIN: begin
                if (b == "0" || b == "1") begin
                    if (num_sat || num_acc[63]) begin
                        num_acc = '1; num_sat = 1'b1;
                    end else num_acc = {num_acc[62:0], b[0]};
                    text_res(b);
                end else begin
                    tok_res(TK_INT, num_acc, 1'b0); lx_mode = M_IDLE; lex_byte(b);
                end
            end
            M_FRAC, M_EXPS, M_EXPD: begin
                if (is_num(b)) begin
                    if (lx_mode == M_EXPS) lx_mode = M_EXPD;
                    text_res(b);
                end else if (lx_mode == M_FRAC && (b == "e" || b == "E")) begin
                    lx_mode = M_EXPS; text_res(b);
                end else if (lx_mode == M_EXPS && (b == "+" || b == "-")) begin
                    lx_mode = M_EXPD; text_res(b);
                end else begin
                    tok_res(TK_FLOAT, '0, 1'b0); lx_mode = M_IDLE; lex_byte(b);
                end
            end
            M_STR: begin
                if (b == "\"") begin tok_res(TK_STR, '0, 1'b0); lx_mode = M_IDLE; end
                else if (b == "\\") lx_mode = M_SESC;
                else text_res(b);
            end
            M_SESC: begin
                if (b == "x") begin esc_acc = '0; esc_digs = '0; lx_mode = M_SHEX; end
                else begin text_res(unescape(b)); lx_mode = M_STR; end
            end
            M_SHEX: begin
                if (is_hexc(b)) begin
                    esc_acc = {esc_acc[3:0], hexv(b)};
                    esc_digs = esc_digs + 2'd1;
                    if (esc_digs >= 2'd2) begin text_res(esc_acc); lx_mode = M_STR; end
                end else begin text_res(esc_acc); lx_mode = M_STR; lex_byte(b); end
            end
            M_COPEN: begin
                if (b == "\\") lx_mode = M_CESC;
                else begin num_acc = {56'd0, b}; lx_mode = M_CCLOSE; end
            end
            M_CESC: begin
                if (b == "x") begin
                    esc_acc = '0; esc_digs = '0; num_acc = '0; lx_mode = M_CHEX;
                end else begin num_acc = {56'd0, unescape(b)}; lx_mode = M_CCLOSE; end
            end
            M_CHEX: begin
                if (is_hexc(b)) begin
                    esc_acc = {esc_acc[3:0], hexv(b)};
                    esc_digs = esc_digs + 2'd1;
                    num_acc = {56'd0, esc_acc};
                    if (esc_digs >= 2'd2) lx_mode = M_CCLOSE;
                end else begin
                    num_acc = {56'd0, esc_acc}; lx_mode = M_CCLOSE; lex_byte(b);
                end
            end
            M_CCLOSE: begin
                lx_mode = M_IDLE;
                if (b == "'") tok_res(TK_CHAR, num_acc, 1'b0);
                else begin tok_res(TK_CHAR, num_acc, 1'b1); lex_byte(b); end
            end
            M_PRAGMA: begin
                if (b == Lf) begin tok_res(TK_PRAGMA, '0, 1'b0); lx_mode = M_IDLE; end
                else text_res(b);
            end
            default: begin lx_mode = M_IDLE; lex_byte(b); end
        endcase
    endfunction

    function automatic void flush_pending();
        case (lx_mode)
            M_PEND:  tok_res(lead_op(pend_op), '0, 1'b0);
            M_SHIFT: tok_res(pend_op == "<" ? TK_SHL : TK_SHR, '0, 1'b0);
            M_IDENT: close_word();
            M_ZERO, M_DEC, M_HEX, M_BIN: tok_res(TK_INT, num_acc, 1'b0);
            M_DOT: begin
                tok_res(TK_INT, num_acc, 1'b0);
                push_res(RK_TOKEN, TK_DOT, '0, cur_line, held_col, 1'b0);
            end
            M_FRAC, M_EXPS, M_EXPD: tok_res(TK_FLOAT, '0, 1'b0);
            M_STR, M_SESC: tok_res(TK_STR, '0, 1'b1);
            M_SHEX:  begin text_res(esc_acc); tok_res(TK_STR, '0, 1'b1); end
            M_COPEN, M_CESC: tok_res(TK_CHAR, '0, 1'b1);
            M_CHEX:  tok_res(TK_CHAR, {56'd0, esc_acc}, 1'b1);
            M_CCLOSE: tok_res(TK_CHAR, num_acc, 1'b1);
            M_PRAGMA: tok_res(TK_PRAGMA, '0, 1'b0);
            default: ;
        endcase
    endfunction

    function automatic void predict_tokens(t_in_item it);
        step_q.delete();
        cur_line = line_c; cur_col = col_c;
        if (it.end_of_input) begin
            flush_pending();
            push_res(RK_TOKEN, TK_END, '0, line_c, col_c, 1'b0);
            clear_lexer();
        end else begin
            lex_byte(it.src_byte);
            if (it.src_byte == Lf) begin
                if (line_c != LineTop) line_c = line_c + 20'd1;
                col_c = 16'd1;
            end else if (col_c != ColTop) col_c = col_c + 16'd1;
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
        foreach (step_q[i]) tokens_due = {tokens_due, step_q[i]};
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, want %0h", what, got, want);
        errors++;
    endtask

    task automatic check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    // one transaction in; random idle before it while idling is enabled
    task automatic send_item(logic [7:0] b, logic eoi);
        t_in_item it;
        it.src_byte = b; it.end_of_input = eoi;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_tokens(it);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_item(8'h00, 1'b1);
    endtask

    task automatic wait_drain();
        int n;
        i_in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        n = 0;
        repeat (8) @(posedge i_clk);
        if (tokens_due.size() != 0) report("results still due", tokens_due.size(), n);
    endtask

    // receive side: check every transaction, stall in random bursts
    int stall_left = 0;
    t_out_item due;
    logic nxt_stall;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (tokens_due.size() == 0) begin
                report("unexpected result", o_out.token_kind, 0);
            end else begin
                due = tokens_due.pop_front();
                check_field("result_kind", o_out.result_kind, due.result_kind);
                check_field("token_kind", o_out.token_kind, due.token_kind);
                check_field("token_value", o_out.token_value, due.token_value);
                check_field("start_line", o_out.start_line, due.start_line);
                check_field("start_column", o_out.start_column, due.start_column);
                check_field("unterminated", o_out.unterminated, due.unterminated);
                check_field("last_of_run", o_out.last_of_run, due.last_of_run);
            end
        end
        if (stall_left > 0) begin
            nxt_stall = 1'b1; stall_left--;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 16) - 1; nxt_stall = 1'b1;
        end else nxt_stall = 1'b0;
        i_out_stall <= nxt_stall;
    end

    function automatic void frag_str(string s);
        for (int i = 0; i < s.len(); i++) frag_q = {frag_q, s[i]};
    endfunction
    function automatic void frag_digits(int n, int base);
        string hexset = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++)
            frag_q = {frag_q, (base == 16 ? hexset[$urandom_range(0, 21)]
                                          : 8'("0") + 8'($urandom_range(0, base - 1)))};
    endfunction

    // builds one mostly well-formed lexeme, sometimes broken or plain noise
    function automatic void make_fragment();
        string idset = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        int n;
        frag_q.delete();
        case ($urandom_range(0, 15))
            0: frag_str(kw_names[$urandom_range(0, 24)]);
            1: begin
                n = $urandom_range(1, 12);
                frag_q = {frag_q, idset[$urandom_range(0, 52)]};
                for (int i = 1; i < n; i++) frag_q = {frag_q, idset[$urandom_range(0, 62)]};
            end
            2: frag_digits($urandom_range(1, 22), 10);
            3: begin
                frag_str($urandom_range(0, 1) ? "0x" : "0X");
                frag_digits($urandom_range(0, 18), 16);
            end
            4: begin
                frag_str($urandom_range(0, 1) ? "0b" : "0B");
                frag_digits($urandom_range(0, 4) == 0 ? 66 : $urandom_range(0, 8), 2);
            end
            5: begin
                frag_digits($urandom_range(1, 3), 10);
                if ($urandom_range(0, 1)) begin
                    frag_str("."); frag_digits($urandom_range(1, 3), 10);
                end
                if ($urandom_range(0, 1)) begin
                    frag_str($urandom_range(0, 1) ? "e" : "E");
                    if ($urandom_range(0, 1)) frag_str($urandom_range(0, 1) ? "+" : "-");
                    frag_digits($urandom_range(0, 2), 10);
                end
            end
            6: begin
                frag_digits($urandom_range(1, 3), 10);
                frag_str($urandom_range(0, 1) ? ".x" : ".;");
            end
            7: begin
                frag_str("\"");
                repeat ($urandom_range(0, 5)) begin
                    case ($urandom_range(0, 5))
                        0: frag_str("\\n");
                        1: frag_str($urandom_range(0, 1) ? "\\t" : "\\r");
                        2: begin frag_str("\\x"); frag_digits($urandom_range(0, 2), 16); end
                        3: frag_str($urandom_range(0, 1) ? "\\0" : "\\q");
                        default: frag_q = {frag_q, 8'($urandom_range(32, 126))};
                    endcase
                end
                if ($urandom_range(0, 7) != 0) frag_str("\"");
            end
            8: begin
                frag_str("'");
                case ($urandom_range(0, 4))
                    0: frag_q = {frag_q, 8'($urandom_range(0, 255))};
                    1: frag_str("\\n");
                    2: begin frag_str("\\x"); frag_digits($urandom_range(0, 2), 16); end
                    3: frag_str("'");
                    default: frag_str("\\\\");
                endcase
                if ($urandom_range(0, 5) != 0) frag_str("'");
            end
            9: begin frag_str("#pragma "); frag_digits($urandom_range(0, 3), 10); frag_str("\n"); end
            10: frag_str("// note ;\n");
            11: frag_str($urandom_range(0, 1) ? "/* a **/" : "/* x * y */");
            12: frag_str(op_names[$urandom_range(0, 44)]);
            13: frag_str($urandom_range(0, 1) ? " \t" : "\r\n");
            default: frag_q = {frag_q, 8'($urandom_range(0, 255))};
        endcase
        if ($urandom_range(0, 2) == 0) frag_str(" ");
    endfunction

    task automatic test_directed();
        send_text("fn x=0xF;'\\n'\"a\\x4g\"#p\n");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_end();
        wait_drain();
    endtask

    // digits and a dot left open at end of input: int, dot and end together
    task automatic test_dot_at_end();
        send_text("\t7.");
        send_end();
        wait_drain();
    endtask

    task automatic test_random_stream(int n_bytes);
        int sent;
        sent = 0;
        while (sent < n_bytes) begin
            make_fragment();
            foreach (frag_q[i]) send_item(frag_q[i], 1'b0);
            sent += frag_q.size();
            if ($urandom_range(0, 11) == 0) send_end();
        end
        send_end();
        wait_drain();
    endtask

    initial begin
        clear_lexer();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        test_directed();
        test_random_stream(170);
        idle_on = 1'b0;
        test_dot_at_end();
        test_random_stream(60);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
